@@ hdl/adsr_pkg.sv @@
`default_nettype none

package adsr_pkg;

  localparam int unsigned LevelW = 16;
  localparam int unsigned DacW   = 12;

  localparam logic [LevelW-1:0] FullScale = 16'hFFFF;

  localparam logic [1:0] MODE_FOUR_STAGE = 2'd0;
  localparam logic [1:0] MODE_AR         = 2'd1;
  localparam logic [1:0] MODE_FREE_RUN   = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_ATTACK  = 3'd1,
    PH_DECAY   = 3'd2,
    PH_SUSTAIN = 3'd3,
    PH_RELEASE = 3'd4
  } phase_e;

  typedef struct packed {
    logic [1:0]        mode;
    phase_e            phase;
    logic              gate_held;
    logic [LevelW-1:0] level;
  } chan_state_t;

  typedef struct packed {
    logic              gate_off;
    logic [1:0]        mode_sel;
    logic [LevelW-1:0] attack_step;
    logic [LevelW-1:0] decay_step;
    logic [LevelW-1:0] sustain_level;
    logic [LevelW-1:0] release_step;
  } tick_t;

endpackage

`default_nettype wire

@@ hdl/adsr_state_ram.sv @@
`default_nettype none

module adsr_state_ram #(
  parameter int unsigned Depth = 2,
  parameter int unsigned AddrW = 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 wr_en_i,
  input  wire logic [AddrW-1:0]     wr_addr_i,
  input  wire adsr_pkg::chan_state_t wr_data_i,
  input  wire logic                 rd_en_i,
  input  wire logic [AddrW-1:0]     rd_addr_i,
  output adsr_pkg::chan_state_t     rd_data_o
);
  import adsr_pkg::*;

  chan_state_t             mem_q [Depth];
  logic        [Depth-1:0] vld_q;
  chan_state_t             rd_data_q;
  logic                    rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  // entries never written read as the reset state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : chan_state_t'('0);

endmodule

`default_nettype wire

@@ hdl/adsr_step.sv @@
`default_nettype none

module adsr_step (
  input  wire adsr_pkg::chan_state_t cur_i,
  input  wire adsr_pkg::tick_t       tick_i,
  output adsr_pkg::chan_state_t      nxt_o
);
  import adsr_pkg::*;

  logic [LevelW:0] atk_sum;
  logic [LevelW:0] dec_floor;
  chan_state_t     st;
  phase_e          ph;
  logic            is_adsr;

  assign is_adsr = (tick_i.mode_sel == MODE_FOUR_STAGE);

  always_comb begin
    st = cur_i;
    if (cur_i.mode != tick_i.mode_sel) begin
      st.mode  = tick_i.mode_sel;
      st.phase = PH_IDLE;
      st.level = '0;
    end
    ph = st.phase;

    // gate edges
    if (tick_i.mode_sel == MODE_FREE_RUN) begin
      if (ph == PH_IDLE) begin
        ph = PH_ATTACK;
      end
    end else begin
      if (!tick_i.gate_off && !st.gate_held) begin
        st.gate_held = 1'b1;
        ph           = PH_ATTACK;
      end else if (tick_i.gate_off && st.gate_held) begin
        st.gate_held = 1'b0;
        if (is_adsr) begin
          ph = PH_RELEASE;
        end
      end
    end

    atk_sum   = {1'b0, st.level} + {1'b0, tick_i.attack_step};
    dec_floor = {1'b0, tick_i.sustain_level} + {1'b0, tick_i.decay_step};

    case (ph)
      PH_ATTACK: begin
        if (atk_sum[LevelW]) begin
          st.level = FullScale;
          ph       = is_adsr ? PH_DECAY : PH_RELEASE;
        end else begin
          st.level = atk_sum[LevelW-1:0];
        end
      end
      PH_DECAY: begin
        if ({1'b0, st.level} < dec_floor) begin
          st.level = tick_i.sustain_level;
          ph       = PH_SUSTAIN;
        end else begin
          st.level = st.level - tick_i.decay_step;
        end
      end
      PH_SUSTAIN: begin
        st.level = tick_i.sustain_level;
      end
      PH_RELEASE: begin
        if (tick_i.release_step > st.level) begin
          st.level = '0;
          ph       = PH_IDLE;
        end else begin
          st.level = st.level - tick_i.release_step;
        end
      end
      default: begin
      end
    endcase

    st.phase = ph;
    nxt_o    = st;
  end

endmodule

`default_nettype wire

@@ hdl/adsr_envelope_generator.sv @@
// Multi-channel envelope generator. Each input item is one tick for one channel; the
// block answers every item with exactly one result (level, 12-bit DAC code, phase).
// It takes one item per clock while the output is not stalled; the result passes through
// the stage-one register and the output register and is held there until it is taken.
// Per-channel state (mode, phase, gate, level) lives in a small state RAM with a
// registered read port; the read-modify-write loop through that RAM sets the rate, and
// a tick for the channel updated in the cycle before is served from a forwarding
// register. No clearing pass follows reset.
`default_nettype none

module adsr_envelope_generator #(
  parameter int unsigned CHANNELS = 2
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        channel_i,
  input  wire logic        gate_off_i,
  input  wire logic [1:0]  mode_sel_i,
  input  wire logic [15:0] attack_step_i,
  input  wire logic [15:0] decay_step_i,
  input  wire logic [15:0] sustain_level_i,
  input  wire logic [15:0] release_step_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             out_channel_o,
  output logic [15:0]      level_o,
  output logic [11:0]      dac_code_o,
  output logic [2:0]       phase_o
);
  import adsr_pkg::*;

  localparam int unsigned AddrW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic             in_fire;
  logic             in_range;
  logic [AddrW-1:0] in_addr;

  logic             s1_valid_q;
  logic             s1_chan_q;
  logic             s1_range_q;
  logic [AddrW-1:0] s1_addr_q;
  tick_t            s1_tick_q;
  logic             s1_adv;
  logic             fwd_q;
  chan_state_t      fwd_state_q;
  chan_state_t      rd_state;
  chan_state_t      cur_state;
  chan_state_t      nxt_state;
  tick_t            in_tick;

  logic             out_valid_q;
  logic             out_chan_q;
  logic [LevelW-1:0] out_level_q;
  phase_e           out_phase_q;
  logic             out_free;

  assign in_range = (32'(channel_i) < CHANNELS);
  assign in_addr  = in_range ? AddrW'(channel_i) : '0;

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;
  assign in_fire    = in_valid_i && in_ready_o;

  assign in_tick = '{
    gate_off:      gate_off_i,
    mode_sel:      mode_sel_i,
    attack_step:   attack_step_i,
    decay_step:    decay_step_i,
    sustain_level: sustain_level_i,
    release_step:  release_step_i
  };

  adsr_state_ram #(
    .Depth (CHANNELS),
    .AddrW (AddrW)
  ) u_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (s1_adv && s1_range_q),
    .wr_addr_i (s1_addr_q),
    .wr_data_i (nxt_state),
    .rd_en_i   (in_fire),
    .rd_addr_i (in_addr),
    .rd_data_o (rd_state)
  );

  assign cur_state = fwd_q ? fwd_state_q : rd_state;

  adsr_step u_step (
    .cur_i  (cur_state),
    .tick_i (s1_tick_q),
    .nxt_o  (nxt_state)
  );

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_chan_q   <= channel_i;
      s1_range_q  <= in_range;
      s1_addr_q   <= in_addr;
      s1_tick_q   <= in_tick;
      fwd_state_q <= nxt_state;
    end
    if (s1_adv) begin
      out_chan_q  <= s1_chan_q;
      out_level_q <= s1_range_q ? nxt_state.level : '0;
      out_phase_q <= s1_range_q ? nxt_state.phase : PH_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
        // write-back of the item ahead lands in the same cycle as this read
        fwd_q      <= s1_adv && s1_range_q && in_range && (s1_addr_q == in_addr);
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
        fwd_q      <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_channel_o = out_chan_q;
  assign level_o       = out_level_q;
  assign dac_code_o    = out_level_q[LevelW-1 -: DacW];
  assign phase_o       = out_phase_q;

  a_idle_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (phase_o == PH_IDLE) |-> (level_o == '0))
    else $error("idle result with nonzero level");

  a_accept_loads : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> s1_valid_q)
    else $error("accepted item lost before stage one");

  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !out_free |=> s1_valid_q && $stable(s1_chan_q) && $stable(s1_tick_q))
    else $error("stalled item changed");

  a_fwd_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_q |-> s1_valid_q && s1_range_q)
    else $error("forwarding without a live item");

endmodule

`default_nettype wire

@@ bench/tb_adsr_envelope_generator.sv @@
`timescale 1ns / 1ps

module tb_adsr_envelope_generator;
  import adsr_pkg::*;

  localparam logic [1:0] MODE_SPARE  = 2'd3;
  localparam bit         GATE_ON     = 1'b0;
  localparam bit         GATE_OFF    = 1'b1;
  localparam int         HOLD_CYCLES = 80;
  localparam int         TICK_TARGET = 550;

  typedef struct {
    logic        channel;
    logic [15:0] level;
    logic [11:0] dac;
    phase_e      phase;
  } level_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        channel_i;
  logic        gate_off_i;
  logic [1:0]  mode_sel_i;
  logic [15:0] attack_step_i;
  logic [15:0] decay_step_i;
  logic [15:0] sustain_level_i;
  logic [15:0] release_step_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        out_channel_o;
  logic [15:0] level_o;
  logic [11:0] dac_code_o;
  logic [2:0]  phase_o;

  // envelope state per channel
  logic [1:0]  chan_mode  [2];
  phase_e      chan_phase [2];
  bit          chan_gate  [2];
  logic [15:0] chan_level [2];

  level_result_t expected_levels[$];
  int          ticks_sent;
  int          fail_count;
  bit          quiet;
  bit          hold_output;

  adsr_envelope_generator #(
    .CHANNELS(2)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .channel_i      (channel_i),
    .gate_off_i     (gate_off_i),
    .mode_sel_i     (mode_sel_i),
    .attack_step_i  (attack_step_i),
    .decay_step_i   (decay_step_i),
    .sustain_level_i(sustain_level_i),
    .release_step_i (release_step_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_channel_o  (out_channel_o),
    .level_o        (level_o),
    .dac_code_o     (dac_code_o),
    .phase_o        (phase_o)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [15:0] pick_step();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 16'h0000;
    if (r < 20) return 16'hFFFF;
    if (r < 60) return 16'($urandom_range(16'h1000, 16'h6000));
    return 16'($urandom);
  endfunction

  function automatic logic [1:0] pick_mode();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return MODE_FOUR_STAGE;
    if (r < 70) return MODE_AR;
    if (r < 90) return MODE_FREE_RUN;
    return MODE_SPARE;
  endfunction

  function automatic level_result_t advance_envelope(input bit ch, input bit gate_off,
                                                     input logic [1:0] mode,
                                                     input logic [15:0] atk, dec, sus, rel);
    level_result_t res;
    int unsigned   lvl;
    phase_e        ph;
    if (chan_mode[ch] != mode) begin
      chan_mode[ch]  = mode;
      chan_phase[ch] = PH_IDLE;
      chan_level[ch] = '0;
    end
    ph  = chan_phase[ch];
    lvl = 32'(chan_level[ch]);
    if (mode == MODE_FREE_RUN) begin
      if (ph == PH_IDLE) ph = PH_ATTACK;
    end else begin
      if (gate_off == GATE_ON && !chan_gate[ch]) begin
        chan_gate[ch] = 1'b1;
        ph = PH_ATTACK;
      end
      if (gate_off == GATE_OFF && chan_gate[ch]) begin
        chan_gate[ch] = 1'b0;
        if (mode == MODE_FOUR_STAGE) ph = PH_RELEASE;
      end
    end
    case (ph)
      PH_ATTACK: begin
        lvl = lvl + 32'(atk);
        if (lvl > 32'(FullScale)) begin
          lvl = 32'(FullScale);
          ph  = (mode == MODE_FOUR_STAGE) ? PH_DECAY : PH_RELEASE;
        end
      end
      PH_DECAY: begin
        if (lvl < 32'(sus) + 32'(dec)) begin
          lvl = 32'(sus);
          ph  = PH_SUSTAIN;
        end else begin
          lvl = lvl - 32'(dec);
        end
      end
      PH_SUSTAIN: lvl = 32'(sus);
      PH_RELEASE: begin
        if (32'(rel) > lvl) begin
          lvl = 0;
          ph  = PH_IDLE;
        end else begin
          lvl = lvl - 32'(rel);
        end
      end
      default: ;
    endcase
    chan_phase[ch] = ph;
    chan_level[ch] = lvl[15:0];
    res.channel = ch;
    res.level   = lvl[15:0];
    res.dac     = lvl[15:4];
    res.phase   = ph;
    return res;
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_tick(input bit ch, input bit gate_off, input logic [1:0] mode,
                           input logic [15:0] atk, dec, sus, rel);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    channel_i       = ch;
    gate_off_i      = gate_off;
    mode_sel_i      = mode;
    attack_step_i   = atk;
    decay_step_i    = dec;
    sustain_level_i = sus;
    release_step_i  = rel;
    in_valid_i      = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    expected_levels.push_back(advance_envelope(ch, gate_off, mode, atk, dec, sus, rel));
    ticks_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_random_tick();
    send_tick(1'($urandom), 1'($urandom), 2'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom), 16'($urandom));
  endtask

  task automatic test_adsr_phases();
    // attack landing exactly on full scale, then overshoot into decay
    send_tick(1'b0, GATE_ON, MODE_FOUR_STAGE, 16'hFFFF, 16'h1000, 16'h8000, 16'h4000);
    send_tick(1'b0, GATE_ON, MODE_FOUR_STAGE, 16'h0001, 16'h1000, 16'h8000, 16'h4000);
    send_tick(1'b0, GATE_ON, MODE_FOUR_STAGE, 16'h0000, 16'h1000, 16'h8000, 16'h4000);
    // decay floor, then sustain follows the live level
    send_tick(1'b0, GATE_ON, MODE_FOUR_STAGE, 16'h0000, 16'hFFFF, 16'h8000, 16'h4000);
    send_tick(1'b0, GATE_ON, MODE_FOUR_STAGE, 16'h0000, 16'hFFFF, 16'h2000, 16'h4000);
    // release and release floor
    send_tick(1'b0, GATE_OFF, MODE_FOUR_STAGE, 16'h0000, 16'h0000, 16'h2000, 16'h0800);
    send_tick(1'b0, GATE_OFF, MODE_FOUR_STAGE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_tick(1'b0, GATE_OFF, MODE_FOUR_STAGE, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_tick(1'b0, GATE_ON, MODE_FOUR_STAGE, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
  endtask

  task automatic test_ar_lfo_and_mode_change();
    send_tick(1'b1, GATE_ON, MODE_AR, 16'h9000, 16'h0000, 16'h0000, 16'h1000);
    send_tick(1'b1, GATE_ON, MODE_AR, 16'h9000, 16'h0000, 16'h0000, 16'h1000);
    // gate off in AR keeps the phase
    send_tick(1'b1, GATE_OFF, MODE_AR, 16'h0000, 16'h0000, 16'h0000, 16'h1000);
    send_tick(1'b1, GATE_ON, MODE_AR, 16'h0100, 16'h0000, 16'h0000, 16'h1000);
    // spare mode code behaves like AR, gate stays held across the change
    send_tick(1'b1, GATE_ON, MODE_SPARE, 16'h0100, 16'h0000, 16'h0000, 16'h1000);
    // free running, gate ignored
    send_tick(1'b1, GATE_OFF, MODE_FREE_RUN, 16'h8000, 16'h0000, 16'h0000, 16'hFFFF);
    send_tick(1'b1, GATE_ON, MODE_FREE_RUN, 16'h8000, 16'h0000, 16'h0000, 16'hFFFF);
    send_tick(1'b1, GATE_OFF, MODE_FREE_RUN, 16'h8000, 16'h0000, 16'h0000, 16'hFFFF);
    send_tick(1'b1, GATE_OFF, MODE_FREE_RUN, 16'h8000, 16'h0000, 16'h0000, 16'h0001);
    send_tick(1'b1, GATE_ON, MODE_FREE_RUN, 16'h1234, 16'h0000, 16'h0000, 16'h0001);
    send_tick(1'b0, GATE_ON, MODE_AR, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_tick(1'b0, GATE_OFF, MODE_FOUR_STAGE, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
  endtask

  task automatic test_output_hold();
    quiet       = 1'b1;
    hold_output = 1'b1;
    repeat (24) send_random_tick();
    quiet = 1'b0;
  endtask

  task automatic test_random_envelopes();
    logic [1:0]  seg_mode [2];
    bit          ch;
    int          n_on;
    int          n_off;
    logic [15:0] atk, dec, sus, rel;
    seg_mode[0] = MODE_FOUR_STAGE;
    seg_mode[1] = MODE_FOUR_STAGE;
    while (ticks_sent < TICK_TARGET) begin
      if ($urandom_range(0, 9) == 0) quiet = !quiet;
      ch = 1'($urandom);
      if ($urandom_range(0, 99) < 15) begin
        send_random_tick();
      end else begin
        if ($urandom_range(0, 4) == 0) seg_mode[ch] = pick_mode();
        atk   = pick_step();
        dec   = pick_step();
        sus   = 16'($urandom);
        rel   = pick_step();
        n_on  = $urandom_range(1, 12);
        n_off = $urandom_range(1, 8);
        repeat (n_on) begin
          if ($urandom_range(0, 4) == 0) sus = 16'($urandom);
          if ($urandom_range(0, 4) == 0)
            send_tick(!ch, 1'($urandom), seg_mode[!ch], pick_step(), pick_step(),
                      16'($urandom), pick_step());
          send_tick(ch, GATE_ON, seg_mode[ch], atk, dec, sus, rel);
        end
        repeat (n_off) send_tick(ch, GATE_OFF, seg_mode[ch], atk, dec, sus, rel);
      end
    end
    quiet = 1'b0;
  endtask

  // receiver side
  initial begin
    int stall_left;
    stall_left  = 0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_output) begin
        hold_output = 1'b0;
        stall_left  = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        out_ready_i = 1'b0;
        stall_left--;
      end else begin
        out_ready_i = 1'b1;
        stall_left  = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    level_result_t exp_res;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_levels.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result: ch %0d level %h phase %0d", out_channel_o, level_o,
                   phase_o);
      end else begin
        exp_res = expected_levels.pop_front();
        if (out_channel_o !== exp_res.channel || level_o !== exp_res.level ||
            dac_code_o !== exp_res.dac || phase_o !== exp_res.phase) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: exp ch %0d level %h dac %h phase %0d,",
                     exp_res.channel, exp_res.level, exp_res.dac, exp_res.phase,
                     " got ch %0d level %h dac %h phase %0d",
                     out_channel_o, level_o, dac_code_o, phase_o);
        end
      end
    end
  end

  initial begin
    #1000000;
    $display("tb_adsr_envelope_generator NOT OK");
    $finish;
  end

  initial begin
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    channel_i       = 1'b0;
    gate_off_i      = GATE_OFF;
    mode_sel_i      = MODE_FOUR_STAGE;
    attack_step_i   = '0;
    decay_step_i    = '0;
    sustain_level_i = '0;
    release_step_i  = '0;
    quiet           = 1'b0;
    hold_output     = 1'b0;
    ticks_sent      = 0;
    fail_count      = 0;
    for (int i = 0; i < 2; i++) begin
      chan_mode[i]  = MODE_FOUR_STAGE;
      chan_phase[i] = PH_IDLE;
      chan_gate[i]  = 1'b0;
      chan_level[i] = '0;
    end
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_adsr_phases();
    test_ar_lfo_and_mode_change();
    test_output_hold();
    test_random_envelopes();

    in_valid_i = 1'b0;
    while (expected_levels.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb_adsr_envelope_generator OK");
    end else begin
      $display("tb_adsr_envelope_generator NOT OK");
    end
    $finish;
  end

endmodule
